// ===== src/ibcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ibcs_pkg: shared types and constants
// Payload structs, queue entry, offset bundle and register codes of the IMU
// bias calibration and scaling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibcs_pkg;

  localparam int unsigned CAL_SAMPLES_DEF = 100;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned RES_W      = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GRAV_W     = 15;
  localparam int unsigned AXES       = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned SHIFT      = 8;

  // lane of the accelerometer z axis
  localparam int unsigned ACCEL_Z    = 5;

  localparam logic [GRAV_W-1:0] GRAVITY_RST    = 15'd16384;
  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 16'd10026;
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 16'd17854;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY    = 2'd0,
    CFG_ACCEL_GAIN = 2'd1,
    CFG_GYRO_GAIN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] rate_x_raw;
    logic signed [RAW_W-1:0] rate_y_raw;
    logic signed [RAW_W-1:0] rate_z_raw;
    logic signed [RAW_W-1:0] accel_x_raw;
    logic signed [RAW_W-1:0] accel_y_raw;
    logic signed [RAW_W-1:0] accel_z_raw;
  } sample_t;

  typedef struct packed {
    logic                    calibrating;
    logic signed [RES_W-1:0] rate_x;
    logic signed [RES_W-1:0] rate_y;
    logic signed [RES_W-1:0] rate_z;
    logic signed [RES_W-1:0] accel_x;
    logic signed [RES_W-1:0] accel_y;
    logic signed [RES_W-1:0] accel_z;
  } result_t;

  // lanes 0..2 gyro x/y/z, lanes 3..5 accel x/y/z
  typedef logic [AXES-1:0][RAW_W-1:0] axes_t;

  typedef struct packed {
    logic  cal;
    axes_t raw;
  } entry_t;

  typedef struct packed {
    logic  valid;
    axes_t off;
  } offs_t;

endpackage

`default_nettype wire

// ===== src/ibcs_stream_if.sv =====
// ----------------------------------------------------------------------------
// ibcs_stream_if: valid/ready stream channel
// Carries one request of payload type T from a source to a sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ibcs_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== src/imu_bias_calibrate_and_scale.sv =====
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_scale: six-axis IMU bias removal and scaling
// Samples enter on smp_i (valid/ready), results leave on res_o (valid/ready).
// The first CAL_SAMPLES samples after reset are summed per axis and reported
// with calibrating set and zero offsets; the last of them starts a reciprocal
// multiply that turns the sums into offsets, accelerometer z less one g.
// Each result is (raw - offset) * gain >>> 8, saturated to 24 bits.
// Throughput is one sample per cycle unless res_o stalls or the queue fills.
// A request passes the queue, then the difference, product and result registers.
// Samples that follow the calibration window wait in a four-entry queue
// until the offsets are ready; once it is full smp_i.ready drops.
// When res_o stalls the scaling pipeline holds, the queue fills and then
// smp_i.ready drops. Reset clears sums, count, offsets-ready and all valids
// and restores the register defaults; no clearing pass is needed.
// Config: cfg_we_i writes register cfg_idx_i (0 gravity counts, 1 accel gain,
// 2 gyro gain) with cfg_wdata_i; other indexes are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_bias_calibrate_and_scale #(
  parameter int unsigned CAL_SAMPLES = ibcs_pkg::CAL_SAMPLES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  ibcs_stream_if.sink                            smp_i,
  ibcs_stream_if.source                          res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ibcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ibcs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned SUM_W = ibcs_pkg::RAW_W + $clog2(CAL_SAMPLES);

  logic [ibcs_pkg::GRAV_W-1:0]           gravity_q;
  logic [ibcs_pkg::GAIN_W-1:0]           accel_gain_q;
  logic [ibcs_pkg::GAIN_W-1:0]           gyro_gain_q;

  logic                                  q_push, q_full, q_pop, q_head_valid;
  ibcs_pkg::entry_t                      q_entry, q_head;
  logic                                  done;
  logic                                  cal_start;
  logic [ibcs_pkg::AXES-1:0][SUM_W-1:0]  sums;
  ibcs_pkg::offs_t                       offs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q    <= ibcs_pkg::GRAVITY_RST;
      accel_gain_q <= ibcs_pkg::ACCEL_GAIN_RST;
      gyro_gain_q  <= ibcs_pkg::GYRO_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (ibcs_pkg::cfg_idx_e'(cfg_idx_i))
        ibcs_pkg::CFG_GRAVITY:    gravity_q    <= cfg_wdata_i[ibcs_pkg::GRAV_W-1:0];
        ibcs_pkg::CFG_ACCEL_GAIN: accel_gain_q <= cfg_wdata_i[ibcs_pkg::GAIN_W-1:0];
        ibcs_pkg::CFG_GYRO_GAIN:  gyro_gain_q  <= cfg_wdata_i[ibcs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ibcs_front #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry),
    .done_o      (done),
    .cal_start_o (cal_start),
    .sums_o      (sums)
  );

  ibcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .entry_i      (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  ibcs_div #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SUM_W       (SUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cal_start),
    .sums_i    (sums),
    .gravity_i (gravity_q),
    .offs_o    (offs)
  );

  ibcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .offs_i       (offs),
    .gyro_gain_i  (gyro_gain_q),
    .accel_gain_i (accel_gain_q),
    .pop_o        (q_pop),
    .res_o        (res_o)
  );

`ifndef NO_ASSERTIONS
  a_offs_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offs.valid |-> done)
    else $error("offsets ready before calibration window closed");

  a_offs_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offs.valid |=> offs.valid)
    else $error("offsets ready dropped");

  a_pop_needs_offs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !q_head.cal) |-> offs.valid)
    else $error("calibrated request scaled without offsets");

  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_start |=> (done && !offs.valid))
    else $error("divider start out of order");
`endif

endmodule

`default_nettype wire

// ===== src/ibcs_front.sv =====
// ----------------------------------------------------------------------------
// ibcs_front: sample intake and bias accumulation
// Accepts samples, sums the first CAL_SAMPLES of them per axis, tags each
// request with its calibration state and pushes it into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibcs_front #(
  parameter int unsigned CAL_SAMPLES = ibcs_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned SUM_W       = ibcs_pkg::RAW_W + $clog2(CAL_SAMPLES)
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  ibcs_stream_if.sink                                     smp_i,
  input  wire logic                                       q_full_i,
  output logic                                            q_push_o,
  output ibcs_pkg::entry_t                                q_entry_o,
  output logic                                            done_o,
  output logic                                            cal_start_o,
  output logic [ibcs_pkg::AXES-1:0][SUM_W-1:0]            sums_o
);

  localparam int unsigned CNT_W = $clog2(CAL_SAMPLES + 1);

  ibcs_pkg::axes_t                         raw;
  logic [ibcs_pkg::AXES-1:0][SUM_W-1:0]    sums_q, sums_d;
  logic [CNT_W-1:0]                        cnt_q;
  logic                                    done_q;
  logic                                    acc;
  logic                                    last;

  assign raw[0] = smp_i.data.rate_x_raw;
  assign raw[1] = smp_i.data.rate_y_raw;
  assign raw[2] = smp_i.data.rate_z_raw;
  assign raw[3] = smp_i.data.accel_x_raw;
  assign raw[4] = smp_i.data.accel_y_raw;
  assign raw[5] = smp_i.data.accel_z_raw;

  assign smp_i.ready = !q_full_i;
  assign acc         = smp_i.valid && smp_i.ready;
  assign last        = (cnt_q == CNT_W'(CAL_SAMPLES - 1));

  always_comb begin
    for (int i = 0; i < ibcs_pkg::AXES; i++) begin
      sums_d[i] = sums_q[i] + SUM_W'(signed'(raw[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (acc && !done_q) begin
      sums_q <= sums_d;
      cnt_q  <= cnt_q + CNT_W'(1);
      if (last) begin
        done_q <= 1'b1;
      end
    end
  end

  assign q_push_o      = acc;
  assign q_entry_o.cal = !done_q;
  assign q_entry_o.raw = raw;
  assign done_o        = done_q;
  assign cal_start_o   = acc && !done_q && last;
  assign sums_o        = sums_d;

endmodule

`default_nettype wire

// ===== src/ibcs_queue.sv =====
// ----------------------------------------------------------------------------
// ibcs_queue: request queue between intake and scaling
// Small FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibcs_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ibcs_pkg::entry_t entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  head_valid_o,
  output ibcs_pkg::entry_t      head_o
);

  localparam int unsigned PTR_W = $clog2(ibcs_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(ibcs_pkg::QDEPTH + 1);

  ibcs_pkg::entry_t  mem_q [ibcs_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(ibcs_pkg::QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ibcs_div.sv =====
// ----------------------------------------------------------------------------
// ibcs_div: bias offset divider
// Divides the six bias sums by CAL_SAMPLES with a reciprocal multiply on the
// magnitudes, truncating toward zero; removes one g from the accelerometer z
// offset. Offsets are registered in mag_q, quot_q and off_q after start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibcs_div #(
  parameter int unsigned CAL_SAMPLES = ibcs_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned SUM_W       = ibcs_pkg::RAW_W + $clog2(CAL_SAMPLES)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [ibcs_pkg::AXES-1:0][SUM_W-1:0] sums_i,
  input  wire logic [ibcs_pkg::GRAV_W-1:0]         gravity_i,
  output ibcs_pkg::offs_t                          offs_o
);

  localparam int unsigned RAW_W  = ibcs_pkg::RAW_W;
  localparam int unsigned LOG_D  = $clog2(CAL_SAMPLES);
  localparam int unsigned RSH    = SUM_W + LOG_D;
  localparam int unsigned RCP_W  = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + RCP_W;

  // ceil(2^RSH / CAL_SAMPLES)
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RSH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  logic [ibcs_pkg::AXES-1:0][SUM_W-1:0]  mag_q;
  logic [ibcs_pkg::AXES-1:0]             neg_q;
  logic [ibcs_pkg::GRAV_W-1:0]           grav_q;
  logic                                  mul_q;
  logic                                  fin_q;
  logic                                  valid_q;
  ibcs_pkg::axes_t                       quot_q, quot_d;
  ibcs_pkg::axes_t                       off_q, off_d;

  always_comb begin
    for (int i = 0; i < ibcs_pkg::AXES; i++) begin
      quot_d[i] = RAW_W'((PROD_W'(mag_q[i]) * PROD_W'(RECIP)) >> RSH);
      off_d[i]  = neg_q[i] ? (RAW_W'(0) - quot_q[i]) : quot_q[i];
    end
    off_d[ibcs_pkg::ACCEL_Z] = off_d[ibcs_pkg::ACCEL_Z] - RAW_W'(grav_q);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < ibcs_pkg::AXES; i++) begin
        mag_q[i] <= sums_i[i][SUM_W-1] ? (SUM_W'(0) - sums_i[i]) : sums_i[i];
        neg_q[i] <= sums_i[i][SUM_W-1];
      end
      grav_q <= gravity_i;
    end
    if (mul_q) begin
      quot_q <= quot_d;
    end
    if (fin_q) begin
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q   <= 1'b0;
      fin_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      mul_q <= start_i;
      fin_q <= mul_q;
      if (fin_q) begin
        valid_q <= 1'b1;
      end
    end
  end

  assign offs_o.valid = valid_q;
  assign offs_o.off   = off_q;

endmodule

`default_nettype wire

// ===== src/ibcs_back.sv =====
// ----------------------------------------------------------------------------
// ibcs_back: offset removal and scaling pipeline
// Subtract, multiply by gain, shift and saturate in three stages; the whole
// pipeline holds while the output register waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibcs_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         head_valid_i,
  input  wire ibcs_pkg::entry_t             head_i,
  input  wire ibcs_pkg::offs_t              offs_i,
  input  wire logic [ibcs_pkg::GAIN_W-1:0]  gyro_gain_i,
  input  wire logic [ibcs_pkg::GAIN_W-1:0]  accel_gain_i,
  output logic                              pop_o,
  ibcs_stream_if.source                     res_o
);

  localparam int unsigned RAW_W  = ibcs_pkg::RAW_W;
  localparam int unsigned DIFF_W = RAW_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned SHR_W  = ibcs_pkg::RES_W + 2;
  localparam int unsigned AXES   = ibcs_pkg::AXES;

  localparam logic signed [SHR_W-1:0] RES_MAX = SHR_W'((1 << (ibcs_pkg::RES_W - 1)) - 1);
  localparam logic signed [SHR_W-1:0] RES_MIN = -SHR_W'(1 << (ibcs_pkg::RES_W - 1));

  function automatic logic signed [ibcs_pkg::RES_W-1:0] sat_res(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [SHR_W-1:0] s;
    begin
      s = SHR_W'(p >>> ibcs_pkg::SHIFT);
      priority if (s > RES_MAX) begin
        sat_res = RES_MAX[ibcs_pkg::RES_W-1:0];
      end else if (s < RES_MIN) begin
        sat_res = RES_MIN[ibcs_pkg::RES_W-1:0];
      end else begin
        sat_res = s[ibcs_pkg::RES_W-1:0];
      end
    end
  endfunction

  logic                      adv;
  logic                      v1_q, v2_q, out_v_q;
  logic                      cal1_q, cal2_q, out_cal_q;
  logic signed [DIFF_W-1:0]  diff1_q [AXES];
  logic signed [PROD_W-1:0]  prod2_q [AXES];
  logic signed [ibcs_pkg::RES_W-1:0] res_q [AXES];
  logic                      offs_ok;

  assign adv     = !out_v_q || res_o.ready;
  assign offs_ok = head_i.cal || offs_i.valid;
  assign pop_o   = adv && head_valid_i && offs_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= pop_o;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cal1_q    <= head_i.cal;
      cal2_q    <= cal1_q;
      out_cal_q <= cal2_q;
      for (int i = 0; i < AXES; i++) begin
        diff1_q[i] <= DIFF_W'(signed'(head_i.raw[i]))
                    - (head_i.cal ? DIFF_W'(0) : DIFF_W'(signed'(offs_i.off[i])));
        prod2_q[i] <= PROD_W'(diff1_q[i]) * PROD_W'(signed'({1'b0,
                      ((i < 3) ? gyro_gain_i : accel_gain_i)}));
        res_q[i]   <= sat_res(prod2_q[i]);
      end
    end
  end

  assign res_o.valid            = out_v_q;
  assign res_o.data.calibrating = out_cal_q;
  assign res_o.data.rate_x      = res_q[0];
  assign res_o.data.rate_y      = res_q[1];
  assign res_o.data.rate_z      = res_q[2];
  assign res_o.data.accel_x     = res_q[3];
  assign res_o.data.accel_y     = res_q[4];
  assign res_o.data.accel_z     = res_q[5];

endmodule

`default_nettype wire
